### hdl/mrtm_pkg.sv
// Shared constants, codes and entry type of the memory region type map.
package mrtm_pkg;

   localparam int MAX_RANGES_DEF = 64;
   localparam int PAGE_SHIFT     = 12;
   localparam int ADDR_W         = 48;
   localparam int PAGE_W         = ADDR_W - PAGE_SHIFT;
   localparam int LEN_W          = PAGE_W + 1;
   localparam int KIND_W         = 8;
   localparam int OP_W           = 3;
   localparam int STATUS_W       = 2;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = LEN_W;

   localparam logic [LEN_W-1:0] PAGE_LIMIT = LEN_W'(1) << PAGE_W;

   // Opcodes
   localparam logic [OP_W-1:0] OP_INIT       = 3'd0;
   localparam logic [OP_W-1:0] OP_PAINT      = 3'd1;
   localparam logic [OP_W-1:0] OP_FIRST_KIND = 3'd2;
   localparam logic [OP_W-1:0] OP_NEXT_KIND  = 3'd3;
   localparam logic [OP_W-1:0] OP_FIRST_FIT  = 3'd4;
   localparam logic [OP_W-1:0] OP_KIND_AT    = 3'd5;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_UNUSED    = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_PAGES   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSABLE_TYPE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INVALID_TYPE  = 2'd2;

   // Register reset values
   localparam logic [LEN_W-1:0]  TOTAL_PAGES_RST   = 37'd262144;
   localparam logic [KIND_W-1:0] UNUSABLE_TYPE_RST = 8'd0;
   localparam logic [KIND_W-1:0] INVALID_TYPE_RST  = 8'hFF;

   // One range of the table
   typedef struct packed {
      logic [PAGE_W-1:0] base;
      logic [LEN_W-1:0]  len;
      logic [KIND_W-1:0] kind;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

### hdl/mrtm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mrtm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write, then register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

### hdl/memory_region_type_map.sv
// Top level of the memory region type map: range table sequencer and result register.
//
// Usage: a request (opcode, address, page_count, region_kind) enters on the
// req_ channel when req_valid is high and req_stall low. Each request gives
// exactly one response on the rsp_ channel. req_stall is high from acceptance
// until the response has been loaded into the output register, so one request
// is in work at a time; a loaded response waits there while the next request
// is taken.
// A query reads the table entries one at a time through the table RAM's single
// read port, until one matches or every used entry has been scanned. A paint
// reads every used entry in turn, cuts it around the painted range and fills
// each gap between pieces with the unusable kind.
// The table lives in one RAM holding two banks; a paint streams the current
// bank into the other and swaps banks only when the result fits, so a refused
// paint leaves the table untouched.
// Reset: the table becomes one unusable range at base 0, written in the boot
// state right after reset with req_stall high. Registers take their reset
// values and may be written at any cycle through the csr_ port.
// A stalled response holds its payload until rsp_stall falls.
module memory_region_type_map #(
   parameter int MAX_RANGES = mrtm_pkg::MAX_RANGES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [mrtm_pkg::OP_W-1:0]         req_opcode,
   input  logic [mrtm_pkg::ADDR_W-1:0]       req_address,
   input  logic [mrtm_pkg::LEN_W-1:0]        req_page_count,
   input  logic [mrtm_pkg::KIND_W-1:0]       req_region_kind,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [mrtm_pkg::ADDR_W-1:0]       rsp_base_address,
   output logic [mrtm_pkg::LEN_W-1:0]        rsp_range_pages,
   output logic [mrtm_pkg::KIND_W-1:0]       rsp_found_kind,
   output logic [mrtm_pkg::STATUS_W-1:0]     rsp_status,
   input  logic                              csr_write_enable,
   input  logic [mrtm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mrtm_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   localparam int IW        = $clog2(MAX_RANGES);
   localparam int CW        = $clog2(MAX_RANGES + 1);
   localparam int RAM_DEPTH = 2 * (2 ** IW);
   localparam int RAW       = IW + 1;
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RANGES);

   localparam int PW = mrtm_pkg::PAGE_W;
   localparam int LW = mrtm_pkg::LEN_W;
   localparam int KW = mrtm_pkg::KIND_W;
   localparam int AW = mrtm_pkg::ADDR_W;
   localparam int PS = mrtm_pkg::PAGE_SHIFT;

   typedef enum logic [3:0] {
      S_BOOT, S_IDLE, S_INIT, S_QREAD, S_QLOAD, S_PSETUP, S_PSETUP2,
      S_PREAD, S_PLOAD, S_PSLOT, S_PTAIL, S_PFLUSH, S_RESP
   } state_type;

   state_type state_ff;

   // Registers
   logic [LW-1:0]                 total_ff;
   logic [KW-1:0]                 unusable_ff;
   logic [KW-1:0]                 invalid_ff;
   logic [mrtm_pkg::OP_W-1:0]     op_ff;
   logic [AW-1:0]                 addr_ff;
   logic [LW-1:0]                 cnt_ff;
   logic [KW-1:0]                 kind_ff;
   logic [PW-1:0]                 s_ff;
   logic [LW-1:0]                 e_ff;
   logic                          bank_ff;
   logic [CW-1:0]                 used_ff;
   logic [CW-1:0]                 idx_ff;
   mrtm_pkg::entry_type           ent_ff;
   logic [1:0]                    slot_ff;
   logic                          placed_ff;
   logic                          lv_ff;
   mrtm_pkg::entry_type           last_ff;
   logic [CW-1:0]                 oidx_ff;
   logic                          ovf_ff;
   logic [AW-1:0]                 res_base_ff;
   logic [LW-1:0]                 res_pages_ff;
   logic [KW-1:0]                 res_kind_ff;
   logic [mrtm_pkg::STATUS_W-1:0] res_status_ff;

   // Table RAM
   logic                          ram_we;
   logic [RAW-1:0]                ram_waddr;
   mrtm_pkg::entry_type           ram_wdata;
   logic [RAW-1:0]                ram_raddr;
   logic [mrtm_pkg::ENTRY_W-1:0]  ram_rdata;
   mrtm_pkg::entry_type           rd_ent;

   mrtm_ram #(
      .WIDTH (mrtm_pkg::ENTRY_W),
      .DEPTH (RAM_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_ent    = mrtm_pkg::entry_type'(ram_rdata);
   assign ram_raddr = {bank_ff, idx_ff[IW-1:0]};
   assign req_stall = (state_ff != S_IDLE);

   // Paint piece selection for the current entry
   logic [PW+1:0]        ent_end;
   logic [PW+1:0]        s_ext;
   logic [PW+1:0]        e_ext;
   logic                 nonover;
   logic                 b_lt_s;
   logic                 end_gt_e;
   logic                 pc_en;
   mrtm_pkg::entry_type  pc;
   mrtm_pkg::entry_type  paint_pc;

   assign ent_end  = {2'b00, ent_ff.base} + {1'b0, ent_ff.len};
   assign s_ext    = {2'b00, s_ff};
   assign e_ext    = {1'b0, e_ff};
   assign nonover  = (ent_end <= s_ext) || ({2'b00, ent_ff.base} >= e_ext);
   assign b_lt_s   = ent_ff.base < s_ff;
   assign end_gt_e = ent_end > e_ext;
   assign paint_pc = '{base: s_ff, len: cnt_ff, kind: kind_ff};

   always_comb begin
      pc_en = 1'b0;
      pc    = paint_pc;
      if (state_ff == S_PTAIL) begin
         pc_en = !placed_ff;
      end else begin
         case (slot_ff)
            2'd0: begin
               pc_en = !nonover && b_lt_s;
               pc    = '{base: ent_ff.base, len: LW'(s_ff - ent_ff.base), kind: ent_ff.kind};
            end
            2'd1: begin
               pc_en = !placed_ff && (nonover ? !b_lt_s : end_gt_e);
            end
            default: begin
               if (nonover) begin
                  pc_en = 1'b1;
                  pc    = ent_ff;
               end else begin
                  pc_en = end_gt_e;
                  pc    = '{base: e_ff[PW-1:0], len: LW'(ent_end - e_ext), kind: ent_ff.kind};
               end
            end
         endcase
      end
   end

   // Gap fill and merge against the held last run
   logic [LW-1:0]        last_end;
   logic                 pc_live;
   logic                 gap_need;
   mrtm_pkg::entry_type  run;
   logic                 merge;
   logic                 append;
   logic                 room;

   assign last_end = {1'b0, last_ff.base} + last_ff.len;
   assign pc_live  = pc_en && (pc.len != '0);
   assign gap_need = pc_live && lv_ff && (last_end < {1'b0, pc.base});
   assign run      = gap_need ?
                     '{base: last_end[PW-1:0], len: {1'b0, pc.base} - last_end,
                       kind: unusable_ff} : pc;
   assign merge    = lv_ff && (last_ff.kind == run.kind) && (last_end == {1'b0, run.base});
   assign append   = pc_live && !merge;
   assign room     = oidx_ff < MAX_CNT;

   // Query match on the word just read
   logic [PW+1:0] q_end;
   logic          q_hit;

   assign q_end = {2'b00, rd_ent.base} + {1'b0, rd_ent.len};

   always_comb begin
      case (op_ff)
         mrtm_pkg::OP_FIRST_KIND: q_hit = rd_ent.kind == kind_ff;
         mrtm_pkg::OP_NEXT_KIND:  q_hit = (rd_ent.kind == kind_ff) &&
                                          ({rd_ent.base, {PS{1'b0}}} >= addr_ff);
         mrtm_pkg::OP_FIRST_FIT:  q_hit = (rd_ent.kind == kind_ff) && (rd_ent.len >= cnt_ff);
         default:                 q_hit = ({rd_ent.base, {PS{1'b0}}} <= addr_ff) &&
                                          ({2'b00, addr_ff} <= {q_end, {PS{1'b0}}});
      endcase
   end

   // Table RAM write port
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = {!bank_ff, oidx_ff[IW-1:0]};
      ram_wdata = last_ff;
      unique case (state_ff)
         S_BOOT: begin
            ram_we    = 1'b1;
            ram_waddr = {bank_ff, {IW{1'b0}}};
            ram_wdata = '{base: '0, len: mrtm_pkg::TOTAL_PAGES_RST,
                          kind: mrtm_pkg::UNUSABLE_TYPE_RST};
         end
         S_INIT: begin
            ram_we    = 1'b1;
            ram_waddr = {bank_ff, {IW{1'b0}}};
            ram_wdata = '{base: '0,
                          len: (total_ff > mrtm_pkg::PAGE_LIMIT) ? mrtm_pkg::PAGE_LIMIT : total_ff,
                          kind: unusable_ff};
         end
         S_PSLOT, S_PTAIL: ram_we = append && lv_ff && room;
         S_PFLUSH:         ram_we = lv_ff && room;
         default:          ram_we = 1'b0;
      endcase
   end

   // Clamp of the paint length at the page space limit
   logic [LW-1:0] paint_room;
   assign paint_room = mrtm_pkg::PAGE_LIMIT - {1'b0, s_ff};

   // Sequencer, table state and registered response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_BOOT;
         rsp_valid     <= 1'b0;
         bank_ff       <= 1'b0;
         used_ff       <= CW'(1);
         total_ff      <= mrtm_pkg::TOTAL_PAGES_RST;
         unusable_ff   <= mrtm_pkg::UNUSABLE_TYPE_RST;
         invalid_ff    <= mrtm_pkg::INVALID_TYPE_RST;
         placed_ff     <= 1'b0;
         lv_ff         <= 1'b0;
         ovf_ff        <= 1'b0;
         oidx_ff       <= '0;
         idx_ff        <= '0;
         slot_ff       <= '0;
      end else begin
         // Take register writes
         if (csr_write_enable) begin
            case (csr_index)
               mrtm_pkg::CSR_TOTAL_PAGES:   total_ff    <= csr_write_data;
               mrtm_pkg::CSR_UNUSABLE_TYPE: unusable_ff <= csr_write_data[KW-1:0];
               mrtm_pkg::CSR_INVALID_TYPE:  invalid_ff  <= csr_write_data[KW-1:0];
               default: ;
            endcase
         end

         // Drop a delivered response unless the next one is loaded now
         if (rsp_valid && !rsp_stall && (state_ff != S_RESP)) begin
            rsp_valid <= 1'b0;
         end

         unique case (state_ff)
            S_BOOT: begin
               used_ff  <= CW'(1);
               state_ff <= S_IDLE;
            end

            S_IDLE: begin
               if (req_valid) begin
                  op_ff         <= req_opcode;
                  addr_ff       <= req_address;
                  cnt_ff        <= req_page_count;
                  kind_ff       <= req_region_kind;
                  s_ff          <= req_address[AW-1:PS];
                  idx_ff        <= '0;
                  res_base_ff   <= '0;
                  res_pages_ff  <= '0;
                  res_kind_ff   <= invalid_ff;
                  res_status_ff <= mrtm_pkg::ST_NOT_FOUND;
                  case (req_opcode)
                     mrtm_pkg::OP_INIT:  state_ff <= S_INIT;
                     mrtm_pkg::OP_PAINT: state_ff <= S_PSETUP;
                     mrtm_pkg::OP_FIRST_KIND, mrtm_pkg::OP_NEXT_KIND,
                     mrtm_pkg::OP_FIRST_FIT, mrtm_pkg::OP_KIND_AT:
                                         state_ff <= S_QREAD;
                     default:            state_ff <= S_RESP;
                  endcase
               end
            end

            S_INIT: begin
               used_ff       <= CW'(1);
               res_status_ff <= mrtm_pkg::ST_OK;
               state_ff      <= S_RESP;
            end

            S_QREAD: begin
               state_ff <= (idx_ff >= used_ff) ? S_RESP : S_QLOAD;
            end

            S_QLOAD: begin
               if (q_hit) begin
                  res_base_ff   <= {rd_ent.base, {PS{1'b0}}};
                  res_pages_ff  <= rd_ent.len;
                  res_kind_ff   <= rd_ent.kind;
                  res_status_ff <= mrtm_pkg::ST_OK;
                  state_ff      <= S_RESP;
               end else begin
                  idx_ff   <= idx_ff + CW'(1);
                  state_ff <= S_QREAD;
               end
            end

            S_PSETUP: begin
               if (cnt_ff > paint_room) begin
                  cnt_ff <= paint_room;
               end
               placed_ff <= 1'b0;
               lv_ff     <= 1'b0;
               ovf_ff    <= 1'b0;
               oidx_ff   <= '0;
               state_ff  <= S_PSETUP2;
            end

            S_PSETUP2: begin
               e_ff     <= {1'b0, s_ff} + cnt_ff;
               state_ff <= S_PREAD;
            end

            S_PREAD: begin
               state_ff <= (idx_ff >= used_ff) ? S_PTAIL : S_PLOAD;
            end

            S_PLOAD: begin
               ent_ff   <= rd_ent;
               slot_ff  <= '0;
               state_ff <= S_PSLOT;
            end

            S_PSLOT, S_PTAIL: begin
               // Fold the next run into the held last run
               if (pc_live) begin
                  if (merge) begin
                     last_ff.len <= last_ff.len + run.len;
                  end else begin
                     last_ff <= run;
                     lv_ff   <= 1'b1;
                     if (lv_ff) begin
                        if (room) begin
                           oidx_ff <= oidx_ff + CW'(1);
                        end else begin
                           ovf_ff <= 1'b1;
                        end
                     end
                  end
               end
               // Advance unless a gap was filled first
               if (!gap_need) begin
                  if (state_ff == S_PTAIL) begin
                     placed_ff <= 1'b1;
                     state_ff  <= S_PFLUSH;
                  end else begin
                     if ((slot_ff == 2'd1) && pc_en) begin
                        placed_ff <= 1'b1;
                     end
                     if (slot_ff == 2'd2) begin
                        idx_ff   <= idx_ff + CW'(1);
                        state_ff <= S_PREAD;
                     end else begin
                        slot_ff <= slot_ff + 2'd1;
                     end
                  end
               end
            end

            S_PFLUSH: begin
               if (ovf_ff || (lv_ff && !room)) begin
                  res_status_ff <= mrtm_pkg::ST_FULL;
               end else begin
                  res_status_ff <= mrtm_pkg::ST_OK;
                  bank_ff       <= !bank_ff;
                  used_ff       <= oidx_ff + CW'(lv_ff);
               end
               state_ff <= S_RESP;
            end

            S_RESP: begin
               if (!rsp_valid || !rsp_stall) begin
                  rsp_valid        <= 1'b1;
                  rsp_base_address <= res_base_ff;
                  rsp_range_pages  <= res_pages_ff;
                  rsp_found_kind   <= res_kind_ff;
                  rsp_status       <= res_status_ff;
                  state_ff         <= S_IDLE;
               end
            end

            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

### hdl/mrtm_checker.sv
// Port-level checker for the memory region type map, bound to the top level.
module mrtm_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [mrtm_pkg::ADDR_W-1:0]       rsp_base_address,
   input logic [mrtm_pkg::LEN_W-1:0]        rsp_range_pages,
   input logic [mrtm_pkg::STATUS_W-1:0]     rsp_status
);

   // Response register is empty after reset
   a_rsp_clear: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // One request in work at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   // Only defined status codes
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != mrtm_pkg::ST_UNUSED)
      else $error("undefined status");

   // Miss or refusal carries an empty range
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != mrtm_pkg::ST_OK |->
         rsp_base_address == '0 && rsp_range_pages == '0)
      else $error("non-empty range on failed response");

endmodule

bind memory_region_type_map mrtm_checker u_mrtm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_base_address (rsp_base_address),
   .rsp_range_pages  (rsp_range_pages),
   .rsp_status       (rsp_status)
);

### dv/tb_top.sv
// Self-checking testbench for the memory region type map: range-table predictor and scoreboard.
`timescale 1ns / 100ps

module tb_top;

   localparam int  OP_W        = mrtm_pkg::OP_W;
   localparam int  ADDR_W      = mrtm_pkg::ADDR_W;
   localparam int  LEN_W       = mrtm_pkg::LEN_W;
   localparam int  KIND_W      = mrtm_pkg::KIND_W;
   localparam int  STATUS_W    = mrtm_pkg::STATUS_W;
   localparam int  PAGE_W      = mrtm_pkg::PAGE_W;
   localparam int  PAGE_SHIFT  = mrtm_pkg::PAGE_SHIFT;
   localparam int  CSR_IDX_W   = mrtm_pkg::CSR_IDX_W;
   localparam int  CSR_DATA_W  = mrtm_pkg::CSR_DATA_W;
   localparam int  TABLE_DEPTH = mrtm_pkg::MAX_RANGES_DEF;
   localparam int  PIECE_DEPTH = TABLE_DEPTH + 4;
   localparam int  RUN_DEPTH   = 2 * TABLE_DEPTH + 8;
   localparam int  CYCLE_LIMIT = 3000000;
   localparam longint unsigned PAGE_SPACE = longint'(1) << PAGE_W;

   typedef struct packed {
      logic [ADDR_W-1:0]   base;
      logic [LEN_W-1:0]    pages;
      logic [KIND_W-1:0]   kind;
      logic [STATUS_W-1:0] status;
   } map_result_type;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [ADDR_W-1:0]   addr;
      logic [LEN_W-1:0]    count;
      logic [KIND_W-1:0]   kind;
      logic                typed;
      map_result_type      want;
   } request_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [OP_W-1:0]       req_opcode;
   logic [ADDR_W-1:0]     req_address;
   logic [LEN_W-1:0]      req_page_count;
   logic [KIND_W-1:0]     req_region_kind;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [ADDR_W-1:0]     rsp_base_address;
   logic [LEN_W-1:0]      rsp_range_pages;
   logic [KIND_W-1:0]     rsp_found_kind;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   memory_region_type_map dut (.*);

   // Predicted register copies and range table
   logic [LEN_W-1:0]  cfg_total_pages;
   logic [KIND_W-1:0] cfg_unusable;
   logic [KIND_W-1:0] cfg_invalid;
   logic [PAGE_W-1:0] map_base [TABLE_DEPTH];
   logic [LEN_W-1:0]  map_len  [TABLE_DEPTH];
   logic [KIND_W-1:0] map_kind [TABLE_DEPTH];
   int                map_used;

   // Scratch lists for building a painted table
   longint unsigned   piece_base [PIECE_DEPTH];
   longint unsigned   piece_len  [PIECE_DEPTH];
   logic [KIND_W-1:0] piece_kind [PIECE_DEPTH];
   int                piece_n;
   longint unsigned   run_base [RUN_DEPTH];
   longint unsigned   run_len  [RUN_DEPTH];
   logic [KIND_W-1:0] run_kind [RUN_DEPTH];
   int                run_n;

   map_result_type pending_results[$];
   int  fail_count;
   int  sent_count;
   int  rsp_count;
   int  full_count;
   int  hit_count;
   int  miss_count;
   int  cycle_count;
   bit  calm;
   bit  pressure_done;

   // Clock
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Table predictor
   function automatic void reset_table();
      map_base[0] = '0;
      map_len[0]  = (cfg_total_pages > LEN_W'(PAGE_SPACE)) ? LEN_W'(PAGE_SPACE) : cfg_total_pages;
      map_kind[0] = cfg_unusable;
      map_used    = 1;
   endfunction

   function automatic void add_piece(longint unsigned b, longint unsigned l, logic [KIND_W-1:0] k);
      if (piece_n < PIECE_DEPTH) begin
         piece_base[piece_n] = b;
         piece_len[piece_n]  = l;
         piece_kind[piece_n] = k;
         piece_n++;
      end
   endfunction

   function automatic void add_run(longint unsigned b, longint unsigned l, logic [KIND_W-1:0] k);
      if (run_n > 0 && run_kind[run_n-1] == k && run_base[run_n-1] + run_len[run_n-1] == b) begin
         run_len[run_n-1] += l;
      end else if (run_n < RUN_DEPTH) begin
         run_base[run_n] = b;
         run_len[run_n]  = l;
         run_kind[run_n] = k;
         run_n++;
      end
   endfunction

   // Drop empty pieces, fill gaps with the unusable kind, merge equal neighbours
   function automatic void add_clean(longint unsigned b, longint unsigned l, logic [KIND_W-1:0] k);
      longint unsigned last_end;
      if (l == 0) return;
      if (run_n > 0) begin
         last_end = run_base[run_n-1] + run_len[run_n-1];
         if (last_end < b) add_run(last_end, b - last_end, cfg_unusable);
      end
      add_run(b, l, k);
   endfunction

   function automatic logic [STATUS_W-1:0] paint_range(longint unsigned addr, longint unsigned cnt,
                                                      logic [KIND_W-1:0] k);
      longint unsigned s, e, b, l, stop;
      bit placed;
      s = addr >> PAGE_SHIFT;
      if (cnt > PAGE_SPACE - s) cnt = PAGE_SPACE - s;
      e = s + cnt;
      placed = 0;
      piece_n = 0;
      for (int i = 0; i < map_used; i++) begin
         b = 64'(map_base[i]);
         l = 64'(map_len[i]);
         stop = b + l;
         if (stop <= s || b >= e) begin
            if (!placed && b >= s) begin
               add_piece(s, cnt, k);
               placed = 1;
            end
            add_piece(b, l, map_kind[i]);
         end else begin
            if (b < s) add_piece(b, s - b, map_kind[i]);
            if (stop > e) begin
               if (!placed) begin
                  add_piece(s, cnt, k);
                  placed = 1;
               end
               add_piece(e, stop - e, map_kind[i]);
            end
         end
      end
      if (!placed) add_piece(s, cnt, k);
      run_n = 0;
      for (int i = 0; i < piece_n; i++) add_clean(piece_base[i], piece_len[i], piece_kind[i]);
      if (run_n > TABLE_DEPTH) return mrtm_pkg::ST_FULL;
      for (int i = 0; i < run_n; i++) begin
         map_base[i] = PAGE_W'(run_base[i]);
         map_len[i]  = LEN_W'(run_len[i]);
         map_kind[i] = run_kind[i];
      end
      map_used = run_n;
      return mrtm_pkg::ST_OK;
   endfunction

   function automatic map_result_type predict_request(logic [OP_W-1:0] op,
                                                      logic [ADDR_W-1:0] addr,
                                                      logic [LEN_W-1:0] cnt,
                                                      logic [KIND_W-1:0] k);
      map_result_type r;
      longint unsigned lo, hi, a64;
      bit hit;
      a64 = 64'(addr);
      r = '{base: '0, pages: '0, kind: cfg_invalid, status: mrtm_pkg::ST_NOT_FOUND};
      if (op == mrtm_pkg::OP_INIT) begin
         reset_table();
         r.status = mrtm_pkg::ST_OK;
      end else if (op == mrtm_pkg::OP_PAINT) begin
         r.status = paint_range(a64, 64'(cnt), k);
      end else if (op inside {mrtm_pkg::OP_FIRST_KIND, mrtm_pkg::OP_NEXT_KIND,
                              mrtm_pkg::OP_FIRST_FIT, mrtm_pkg::OP_KIND_AT}) begin
         for (int i = 0; i < map_used; i++) begin
            lo = longint'(map_base[i]) << PAGE_SHIFT;
            hi = (longint'(map_base[i]) + longint'(map_len[i])) << PAGE_SHIFT;
            case (op)
               mrtm_pkg::OP_FIRST_KIND: hit = map_kind[i] == k;
               mrtm_pkg::OP_NEXT_KIND:  hit = map_kind[i] == k && lo >= a64;
               mrtm_pkg::OP_FIRST_FIT:  hit = map_kind[i] == k && map_len[i] >= cnt;
               default:                 hit = a64 >= lo && a64 <= hi;
            endcase
            if (hit) begin
               r = '{base: ADDR_W'(lo), pages: map_len[i], kind: map_kind[i],
                     status: mrtm_pkg::ST_OK};
               break;
            end
         end
      end
      return r;
   endfunction

   // Gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 15);
      return $urandom_range(40, 120);
   endfunction

   function automatic logic [KIND_W-1:0] pick_kind();
      case ($urandom_range(0, 5))
         0: return cfg_unusable;
         1: return 8'd1;
         2: return 8'd2;
         3: return 8'd3;
         4: return cfg_invalid;
         default: return KIND_W'($urandom);
      endcase
   endfunction

   // Offer one request, hold it until accepted, then record its expected response
   task automatic send_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                               logic [LEN_W-1:0] cnt, logic [KIND_W-1:0] k,
                               bit typed, map_result_type want);
      map_result_type pred;
      int gap;
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_address     <= addr;
      req_page_count  <= cnt;
      req_region_kind <= k;
      do @(posedge clock); while (req_stall);
      pred = predict_request(op, addr, cnt, k);
      pending_results.push_back(typed ? want : pred);
      sent_count++;
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_checked(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                               logic [LEN_W-1:0] cnt, logic [KIND_W-1:0] k);
      send_request(op, addr, cnt, k, 1'b0, '0);
   endtask

   // Wait until every response is back, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_config(logic [LEN_W-1:0] total, logic [KIND_W-1:0] unus,
                               logic [KIND_W-1:0] inval);
      csr_write_enable <= 1'b1;
      csr_index        <= mrtm_pkg::CSR_TOTAL_PAGES;
      csr_write_data   <= total;
      @(negedge clock);
      cfg_total_pages = total;
      csr_index        <= mrtm_pkg::CSR_UNUSABLE_TYPE;
      csr_write_data   <= CSR_DATA_W'(unus);
      @(negedge clock);
      cfg_unusable = unus;
      csr_index        <= mrtm_pkg::CSR_INVALID_TYPE;
      csr_write_data   <= CSR_DATA_W'(inval);
      @(negedge clock);
      cfg_invalid = inval;
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_random(int n);
      int stop, r, p0, runs;
      logic [KIND_W-1:0] ka, kb;
      logic [LEN_W-1:0] cnt;
      stop = sent_count + n;
      send_checked(mrtm_pkg::OP_INIT, '0, '0, '0);
      while (sent_count < stop) begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            // stripes of alternating kinds split the table and can fill it
            p0 = $urandom_range(0, 200);
            ka = pick_kind();
            kb = pick_kind();
            runs = $urandom_range(20, 45);
            for (int j = 0; j < runs; j++)
               send_checked(mrtm_pkg::OP_PAINT,
                            (ADDR_W'(p0 + 2 * j) << PAGE_SHIFT) | ADDR_W'($urandom),
                            LEN_W'(1), j[0] ? kb : ka);
         end else if (r < 14) begin
            send_checked(OP_W'($urandom_range(0, 7)), ADDR_W'({$urandom, $urandom}),
                         LEN_W'({$urandom, $urandom}), KIND_W'($urandom));
         end else if (r < 16) begin
            send_checked(mrtm_pkg::OP_INIT, '0, '0, pick_kind());
         end else if (r < 55) begin
            r = $urandom_range(0, 99);
            if (r < 5) cnt = '0;
            else if (r < 8) cnt = LEN_W'({$urandom, $urandom});
            else cnt = LEN_W'($urandom_range(1, 16));
            send_checked(mrtm_pkg::OP_PAINT, (ADDR_W'($urandom_range(0, 700)) << PAGE_SHIFT) |
                         ADDR_W'($urandom_range(0, 4095)), cnt, pick_kind());
         end else begin
            send_checked(OP_W'($urandom_range(mrtm_pkg::OP_FIRST_KIND, mrtm_pkg::OP_KIND_AT)),
                         (ADDR_W'($urandom_range(0, 720)) << PAGE_SHIFT) |
                         ($urandom_range(0, 1) ? ADDR_W'($urandom_range(0, 4095)) : '0),
                         LEN_W'($urandom_range(0, 20)), pick_kind());
         end
      end
   endtask

   task automatic check_field(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
      if (want !== got) begin
         $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // Response scoreboard
   always @(posedge clock) begin
      map_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count++;
         if (pending_results.size() == 0) begin
            $display("%0t unexpected response: status %h", $time, rsp_status);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("base_address", want.base, rsp_base_address);
            check_field("range_pages", ADDR_W'(want.pages), ADDR_W'(rsp_range_pages));
            check_field("found_kind", ADDR_W'(want.kind), ADDR_W'(rsp_found_kind));
            check_field("status", ADDR_W'(want.status), ADDR_W'(rsp_status));
            if (want.status == mrtm_pkg::ST_FULL) full_count++;
            else if (want.status == mrtm_pkg::ST_NOT_FOUND) miss_count++;
            else hit_count++;
         end
      end
   end

   // Receiver back-pressure, with one long hold so the block backs up
   initial begin
      int len;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!pressure_done && rsp_count >= 60) begin
            rsp_stall <= 1'b1;
            repeat (400) @(negedge clock);
            pressure_done = 1'b1;
            rsp_stall <= 1'b0;
         end else begin
            len = pick_gap();
            if (len > 0) begin
               rsp_stall <= 1'b1;
               repeat (len) @(negedge clock);
               rsp_stall <= 1'b0;
            end
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
   end

   // Run watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      request_row_type rows[20];
      map_result_type nothing;
      nothing = '{base: '0, pages: '0, kind: mrtm_pkg::INVALID_TYPE_RST,
                  status: mrtm_pkg::ST_NOT_FOUND};
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_opcode       = mrtm_pkg::OP_INIT;
      req_address      = '0;
      req_page_count   = '0;
      req_region_kind  = '0;
      csr_write_enable = 1'b0;
      csr_index        = mrtm_pkg::CSR_TOTAL_PAGES;
      csr_write_data   = '0;
      fail_count = 0; sent_count = 0; rsp_count = 0; cycle_count = 0;
      full_count = 0; hit_count = 0; miss_count = 0;
      calm = 1'b0; pressure_done = 1'b0;
      cfg_total_pages = mrtm_pkg::TOTAL_PAGES_RST;
      cfg_unusable    = mrtm_pkg::UNUSABLE_TYPE_RST;
      cfg_invalid     = mrtm_pkg::INVALID_TYPE_RST;
      reset_table();

      // Directed table: typed expectations where obvious, predictor otherwise
      rows = '{
         '{mrtm_pkg::OP_KIND_AT, 48'h0, 37'd0, 8'd0, 1'b1,
           '{48'h0, 37'd262144, 8'd0, mrtm_pkg::ST_OK}},
         '{mrtm_pkg::OP_FIRST_KIND, 48'h0, 37'd0, 8'd5, 1'b1, nothing},
         '{3'd6, 48'hFFFF_FFFF_FFFF, 37'h1F_FFFF_FFFF, 8'hFF, 1'b1, nothing},
         '{3'd7, 48'h0, 37'd0, 8'd0, 1'b1, nothing},
         '{mrtm_pkg::OP_PAINT, 48'h1000, 37'd4, 8'd7, 1'b1,
           '{48'h0, 37'd0, 8'hFF, mrtm_pkg::ST_OK}},
         '{mrtm_pkg::OP_FIRST_KIND, 48'h0, 37'd0, 8'd7, 1'b1,
           '{48'h1000, 37'd4, 8'd7, mrtm_pkg::ST_OK}},
         '{mrtm_pkg::OP_NEXT_KIND, 48'h2000, 37'd0, 8'd7, 1'b1, nothing},
         '{mrtm_pkg::OP_FIRST_FIT, 48'h0, 37'd5, 8'd7, 1'b1, nothing},
         '{mrtm_pkg::OP_FIRST_FIT, 48'h0, 37'd4, 8'd7, 1'b1,
           '{48'h1000, 37'd4, 8'd7, mrtm_pkg::ST_OK}},
         '{mrtm_pkg::OP_KIND_AT, 48'h5000, 37'd0, 8'd0, 1'b1,
           '{48'h1000, 37'd4, 8'd7, mrtm_pkg::ST_OK}},
         '{mrtm_pkg::OP_KIND_AT, 48'h0, 37'd0, 8'd0, 1'b1,
           '{48'h0, 37'd1, 8'd0, mrtm_pkg::ST_OK}},
         '{mrtm_pkg::OP_PAINT, 48'hFFFF_FFFF_FFFF, 37'h1F_FFFF_FFFF, 8'd3, 1'b0, '0},
         '{mrtm_pkg::OP_KIND_AT, 48'hFFFF_FFFF_FFFF, 37'd0, 8'd0, 1'b0, '0},
         '{mrtm_pkg::OP_PAINT, 48'h8ABC, 37'd0, 8'd9, 1'b0, '0},
         '{mrtm_pkg::OP_PAINT, 48'h9FFF, 37'd2, 8'hFF, 1'b0, '0},
         '{mrtm_pkg::OP_NEXT_KIND, 48'hFFFF_FFFF_F000, 37'd0, 8'd3, 1'b0, '0},
         '{mrtm_pkg::OP_FIRST_FIT, 48'h0, 37'd0, 8'd0, 1'b0, '0},
         '{mrtm_pkg::OP_PAINT, 48'h0, 37'h1F_FFFF_FFFF, 8'd0, 1'b0, '0},
         '{mrtm_pkg::OP_INIT, 48'h0, 37'd0, 8'd0, 1'b1,
           '{48'h0, 37'd0, 8'hFF, mrtm_pkg::ST_OK}},
         '{mrtm_pkg::OP_FIRST_KIND, 48'h0, 37'd0, 8'd0, 1'b1,
           '{48'h0, 37'd262144, 8'd0, mrtm_pkg::ST_OK}}
      };

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (rows[i])
         send_request(rows[i].op, rows[i].addr, rows[i].count, rows[i].kind,
                      rows[i].typed, rows[i].want);
      run_random(110);
      drain();

      // Zero-size init and inverted type codes
      write_config('0, 8'hFF, 8'h00);
      run_random(120);
      drain();

      // Oversized init saturates at the page space; no idling in this phase
      calm = 1'b1;
      write_config('1, 8'h5A, 8'hA5);
      run_random(120);
      drain();
      calm = 1'b0;

      write_config(37'd1000, 8'd3, 8'd200);
      run_random(120);
      drain();

      $display("Ran %0d requests under four register settings: %0d found, %0d not found,",
               sent_count, hit_count, miss_count);
      $display("%0d paints refused for a full table, with a long receiver hold.", full_count);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
